// ===== hdl/swr_pkg.sv =====
package swr_pkg;

	// store depth, a power of two so the reduction tree stays balanced
	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 32;
	localparam int RANGE_BITS  = 32;
	localparam int SPAN_BITS   = 4;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int LEVELS      = $clog2(MAX_WINDOW);

	localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(3);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [RANGE_BITS-1:0]         range_t;
	typedef logic [SPAN_BITS-1:0]          span_t;
	typedef logic [IDX_W-1:0]              idx_t;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef struct packed {
		logic shift;
		logic clr;
	} swr_cell_ctl_t;

endpackage

// ===== hdl/swr_if.sv =====
interface swr_in_if;
	import swr_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    stream_end;

	modport source (output valid, output sample, output stream_end, input ready);
	modport sink (input valid, input sample, input stream_end, output ready);
endinterface

interface swr_out_if;
	import swr_pkg::*;
	logic   valid;
	logic   ready;
	range_t range_value;
	logic   last_result;

	modport source (output valid, output range_value, output last_result, input ready);
	modport sink (input valid, input range_value, input last_result, output ready);
endinterface

// ===== hdl/swr_cell.sv =====
module swr_cell
	import swr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  swr_cell_ctl_t ctl,
	input  sample_t       prev_sample,
	input  logic          prev_vld,
	output sample_t       sample,
	output logic          vld
);

	sample_t sample_q;
	logic    vld_q;

	// membership bit: dropped when the previous stream has ended
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= prev_vld & ~ctl.clr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			sample_q <= prev_sample;
		end
	end

	assign sample = sample_q;
	assign vld    = vld_q;

endmodule

// ===== hdl/swr_tree.sv =====
module swr_tree
	import swr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_vld,
	input  logic                  in_last,
	input  span_t                 span,
	input  sample_t               cell_sample [MAX_WINDOW],
	input  logic [MAX_WINDOW-1:0] cell_vld,
	output logic                  out_vld,
	output logic                  out_last,
	output sample_t               hi,
	output sample_t               lo
);

	sample_t leaf_hi [MAX_WINDOW];
	sample_t leaf_lo [MAX_WINDOW];
	sample_t node_hi_s [MAX_WINDOW-1];
	sample_t node_lo_s [MAX_WINDOW-1];
	logic    vld_s [LEVELS];
	logic    last_s [LEVELS];
	idx_t    span_idx;
	logic    full;

	// window end clipped to the store depth
	assign span_idx = (int'(span) > MAX_WINDOW - 1) ? idx_t'(MAX_WINDOW - 1) : idx_t'(span);
	assign full     = cell_vld[span_idx];

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_leaf
		logic use_leaf;
		assign use_leaf   = cell_vld[i] && (i <= int'(span));
		assign leaf_hi[i] = use_leaf ? cell_sample[i] : SAMPLE_MIN;
		assign leaf_lo[i] = use_leaf ? cell_sample[i] : SAMPLE_MAX;
	end

	// heap order: node n has children 2n+1 and 2n+2, leaves follow the last node
	for (genvar n = 0; n < MAX_WINDOW - 1; n++) begin : g_node
		localparam int LC = 2 * n + 1;
		localparam int RC = 2 * n + 2;
		sample_t a_hi, a_lo, b_hi, b_lo;
		if (LC >= MAX_WINDOW - 1) begin : g_from_leaf
			assign a_hi = leaf_hi[LC - (MAX_WINDOW - 1)];
			assign a_lo = leaf_lo[LC - (MAX_WINDOW - 1)];
			assign b_hi = leaf_hi[RC - (MAX_WINDOW - 1)];
			assign b_lo = leaf_lo[RC - (MAX_WINDOW - 1)];
		end else begin : g_from_node
			assign a_hi = node_hi_s[LC];
			assign a_lo = node_lo_s[LC];
			assign b_hi = node_hi_s[RC];
			assign b_lo = node_lo_s[RC];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				node_hi_s[n] <= (a_hi > b_hi) ? a_hi : b_hi;
				node_lo_s[n] <= (a_lo < b_lo) ? a_lo : b_lo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEVELS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_vld && (full || in_last);
			for (int k = 1; k < LEVELS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s[0] <= in_last;
			for (int k = 1; k < LEVELS; k++) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	assign out_vld  = vld_s[LEVELS-1];
	assign out_last = last_s[LEVELS-1];
	assign hi       = node_hi_s[0];
	assign lo       = node_lo_s[0];

`ifndef SYNTHESIS
	// a stream end entering the tree always yields a result
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_vld && in_last |=> vld_s[0])
		else $error("stream end produced no result");

	// the tree output holds while the pipe is stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(out_vld))
		else $error("tree output moved during a stall");

	// a finished result never has its maximum below its minimum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> hi >= lo)
		else $error("window maximum below window minimum");
`endif

endmodule

// ===== hdl/sliding_window_range.sv =====
// sliding window range: maximum minus minimum over the last window_span + 1
// samples of a stream of signed samples
//
// din carries one sample per beat with stream_end marking the final sample
// of a stream; dout carries range_value and last_result, one beat for each
// sample once the window has filled, and one for the final sample of a
// stream that ended before filling (range over all samples of that stream)
// cfg_wr_en / cfg_wr_data write window_span; write it only while idle
//
// throughput: one sample per clock; din.ready drops only while a finished
// result sits in the output register and dout.ready is low
// a result reaches dout through the cell, which takes the sample at the
// accepting edge, then the registered max/min tree and the output register
// that holds the subtract
// a stall on dout freezes the whole pipe, chain included, so nothing drops
// reset clears all cell membership bits, the pipe valids and sets
// window_span to 3; the sample registers themselves are not cleared
module sliding_window_range
	import swr_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  span_t          cfg_wr_data,
	swr_in_if.sink         din,
	swr_out_if.source      dout
);

	span_t                 window_span_q;
	logic                  adv;
	logic                  accept;
	logic                  clr_q;
	logic                  vld_s0;
	logic                  last_s0;
	sample_t               cell_sample [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] cell_vld;
	swr_cell_ctl_t         cell_ctl [MAX_WINDOW];
	logic                  tree_vld;
	logic                  tree_last;
	sample_t               tree_hi;
	sample_t               tree_lo;
	logic                  out_vld_q;
	range_t                range_q;
	logic                  last_q;

	// whole pipe moves unless a result is held in the output register
	assign adv       = !out_vld_q || dout.ready;
	assign din.ready = adv;
	assign accept    = din.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_span_q <= SPAN_RESET;
		end else if (cfg_wr_en) begin
			window_span_q <= cfg_wr_data;
		end
	end

	// clr_q remembers that the newest sample in the chain closed its stream,
	// so the older cells drop out of the window on the next beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= 1'b0;
			vld_s0 <= 1'b0;
		end else begin
			if (accept) begin
				clr_q <= din.stream_end;
			end
			if (adv) begin
				vld_s0 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s0 <= din.stream_end;
		end
	end

	// cell chain: newest sample in cell 0, each beat every cell hands its
	// sample to the next one
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		sample_t prev_sample;
		logic    prev_vld;
		if (i == 0) begin : g_head
			assign prev_sample      = din.sample;
			assign prev_vld         = 1'b1;
			assign cell_ctl[i].clr  = 1'b0;
		end else begin : g_body
			assign prev_sample      = cell_sample[i-1];
			assign prev_vld         = cell_vld[i-1];
			assign cell_ctl[i].clr  = clr_q;
		end
		assign cell_ctl[i].shift = accept;

		swr_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl[i]),
			.prev_sample (prev_sample),
			.prev_vld    (prev_vld),
			.sample      (cell_sample[i]),
			.vld         (cell_vld[i])
		);
	end

	// registered max/min reduction over the window cells
	swr_tree u_tree (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (vld_s0),
		.in_last     (last_s0),
		.span        (window_span_q),
		.cell_sample (cell_sample),
		.cell_vld    (cell_vld),
		.out_vld     (tree_vld),
		.out_last    (tree_last),
		.hi          (tree_hi),
		.lo          (tree_lo)
	);

	// output register: range wraps to its width, exact for 32-bit samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tree_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			range_q <= RANGE_BITS'($unsigned(tree_hi) - $unsigned(tree_lo));
			last_q  <= tree_last;
		end
	end

	assign dout.valid       = out_vld_q;
	assign dout.range_value = range_q;
	assign dout.last_result = last_q;

`ifndef SYNTHESIS
	// members of the current stream always form a run starting at cell 0
	a_vld_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld + MAX_WINDOW'(1)) & cell_vld) == '0)
		else $error("cell membership bits not contiguous");

	// a beat after a stream end leaves only the new sample in the window
	a_stream_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && clr_q |=> cell_vld == MAX_WINDOW'(1))
		else $error("old stream samples kept after stream end");

	// the newest cell is always a member once a beat has entered
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cell_vld[0])
		else $error("newest sample not marked in window");
`endif

endmodule
